[design/gpsp_pkg.sv]
package gpsp_pkg;

  localparam int IMAGE_WIDTH  = 640;
  localparam int IMAGE_HEIGHT = 480;
  localparam int MAP_SCALE    = 100;

  // Pipelined restoring divider: 64-bit dividend magnitude, 52-bit divisor,
  // 41 quotient bits plus an overflow flag.
  localparam int DIV_NW  = 64;
  localparam int DIV_DW  = 52;
  localparam int DIV_QW  = 41;
  localparam int DIV_LAT = DIV_QW + 1;

  // Lane depth: slope divide, three product/sum stages, hit divide, nine stages of rotation
  // and mapping.
  localparam int LANE_LAT = 2 * DIV_LAT + 12;

  localparam int SW  = $clog2(MAP_SCALE + 1);
  localparam int QW  = 45;
  localparam int HXW = QW + SW + 1;
  localparam int OXW = HXW - 8;
  localparam int WSW = 62;
  localparam int WYW = 48;
  localparam int HYW = WYW + SW + 1;
  localparam int OYW = HYW - 8;

  localparam logic signed [SW:0] SCALE_S = (SW + 1)'(MAP_SCALE);

  localparam int OX_OFS  = IMAGE_WIDTH * 8;
  localparam int OY_OFS  = IMAGE_HEIGHT * 16;
  localparam int OUT_W   = 18;
  localparam int OUT_MAX = 131071;
  localparam int OUT_MIN = -131072;

  localparam logic [DIV_QW-1:0] VMAX = DIV_QW'(64'h0000_0000_7FFF_FFFF);
  localparam logic [DIV_QW-1:0] PMAX = DIV_QW'(64'h0000_0100_0000_0000);

  typedef enum logic [2:0] {
    REG_FOCAL_X  = 3'd0,
    REG_FOCAL_Y  = 3'd1,
    REG_CENTER_X = 3'd2,
    REG_CENTER_Y = 3'd3,
    REG_HEIGHT   = 3'd4,
    REG_ROLL     = 3'd5,
    REG_PITCH    = 3'd6
  } reg_idx_t;

  typedef struct packed {
    logic [23:0] focal_x;
    logic [23:0] focal_y;
    logic [15:0] center_x;
    logic [15:0] center_y;
    logic [14:0] height;
    logic [31:0] roll;
    logic [31:0] pitch;
  } cfg_t;

  typedef struct packed {
    logic signed [15:0] sr;
    logic signed [15:0] cr;
    logic signed [15:0] sp;
    logic signed [15:0] cp;
    logic signed [17:0] nx;
    logic signed [17:0] ny;
    logic signed [33:0] num;
  } geom_t;

  // Shift right, rounding half away from zero.
  function automatic logic signed [63:0] rshr(input logic signed [63:0] v, input int s);
    logic [63:0] m;
    m = v[63] ? 64'(-v) : 64'(v);
    m = (m + (64'd1 << (s - 1))) >> s;
    return v[63] ? -m : m;
  endfunction

  // {flag, value}: clamp to the 18-bit output range.
  function automatic logic [OUT_W:0] sat_out(input logic signed [63:0] v);
    if (v > 64'(OUT_MAX)) begin
      return {1'b1, OUT_W'(OUT_MAX)};
    end else if (v < 64'(OUT_MIN)) begin
      return {1'b1, OUT_W'(OUT_MIN)};
    end
    return {1'b0, v[OUT_W-1:0]};
  endfunction

endpackage

[design/gpsp_div.sv]
module gpsp_div (
  input  logic                          clk,
  input  logic                          ce,
  input  logic [gpsp_pkg::DIV_NW-1:0]   num,
  input  logic [gpsp_pkg::DIV_DW-1:0]   den,
  output logic [gpsp_pkg::DIV_QW-1:0]   quo,
  output logic                          ovf
);
  import gpsp_pkg::*;

  logic [DIV_DW-1:0] rem_s [DIV_QW];
  logic [DIV_QW-1:0] low_s [DIV_QW];
  logic [DIV_DW-1:0] den_s [DIV_QW];
  logic [DIV_QW-1:0] quo_s [DIV_QW+1];
  logic              ovf_s [DIV_QW+1];

  logic [DIV_DW:0]   trial [DIV_QW];
  logic [DIV_DW:0]   diff  [DIV_QW];
  logic              ge    [DIV_QW];

  // One quotient bit per stage, most significant first.
  always_comb begin
    for (int j = 0; j < DIV_QW; j++) begin
      trial[j] = {rem_s[j], low_s[j][DIV_QW-1-j]};
      ge[j]    = trial[j] >= {1'b0, den_s[j]};
      diff[j]  = trial[j] - {1'b0, den_s[j]};
    end
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      // quotient too large for 41 bits when the top dividend bits already reach the divisor
      rem_s[0] <= DIV_DW'(num[DIV_NW-1:DIV_QW]);
      low_s[0] <= num[DIV_QW-1:0];
      den_s[0] <= den;
      quo_s[0] <= '0;
      ovf_s[0] <= DIV_DW'(num[DIV_NW-1:DIV_QW]) >= den;
      for (int j = 1; j <= DIV_QW; j++) begin
        quo_s[j] <= quo_s[j-1] | (DIV_QW'(ge[j-1]) << (DIV_QW - j));
        ovf_s[j] <= ovf_s[j-1];
      end
      for (int j = 1; j < DIV_QW; j++) begin
        rem_s[j] <= ge[j-1] ? diff[j-1][DIV_DW-1:0] : trial[j-1][DIV_DW-1:0];
        low_s[j] <= low_s[j-1];
        den_s[j] <= den_s[j-1];
      end
    end
  end

  assign quo = quo_s[DIV_QW];
  assign ovf = ovf_s[DIV_QW];

endmodule

[design/gpsp_lane.sv]
module gpsp_lane (
  input  logic                               clk,
  input  logic                               ce,
  input  logic [15:0]                        pos_x,
  input  logic [15:0]                        pos_y,
  input  gpsp_pkg::cfg_t                     cfg,
  input  gpsp_pkg::geom_t                    geom,
  output logic signed [gpsp_pkg::OXW-1:0]    ox,
  output logic signed [gpsp_pkg::OYW-1:0]    oy,
  output logic                               flag
);
  import gpsp_pkg::*;

  typedef struct packed {
    logic       den0;
    logic       flag;
    logic [2:0] neg;
    logic [2:0] pos;
    logic [2:0] nz;
  } side_t;

  function automatic logic [42:0] hit_sat(input logic [DIV_QW-1:0] q, input logic ovf,
                                          input logic neg, input logic den0,
                                          input logic pos, input logic nz);
    logic [41:0] m;
    logic        big;
    big = ovf || (q > PMAX);
    m   = big ? {1'b0, PMAX} : {1'b0, q};
    if (den0) begin
      m = nz ? {1'b0, PMAX} : '0;
      return {1'b1, pos ? m : -m};
    end
    return {big, neg ? -m : m};
  endfunction

  // ray slopes
  logic [16:0]        dx, dy;
  logic [15:0]        ax, ay;
  logic [23:0]        fx, fy;
  logic [DIV_QW-1:0]  qx_raw, qy_raw;
  logic               ovf_x, ovf_y;
  logic [1:0]         sgn_dly [DIV_LAT];

  assign dx = {1'b0, pos_x} - {1'b0, cfg.center_x};
  assign dy = {1'b0, pos_y} - {1'b0, cfg.center_y};
  assign ax = dx[16] ? 16'(-dx) : dx[15:0];
  assign ay = dy[16] ? 16'(-dy) : dy[15:0];
  assign fx = (cfg.focal_x == '0) ? 24'd1 : cfg.focal_x;
  assign fy = (cfg.focal_y == '0) ? 24'd1 : cfg.focal_y;

  gpsp_div u_div_x (
    .clk (clk), .ce (ce),
    .num ({28'd0, ax, 20'd0}), .den ({28'd0, fx}),
    .quo (qx_raw), .ovf (ovf_x)
  );

  gpsp_div u_div_y (
    .clk (clk), .ce (ce),
    .num ({28'd0, ay, 20'd0}), .den ({28'd0, fy}),
    .quo (qy_raw), .ovf (ovf_y)
  );

  always_ff @(posedge clk) begin
    if (ce) begin
      sgn_dly[0] <= {dy[16], dx[16]};
      for (int i = 1; i < DIV_LAT; i++) begin
        sgn_dly[i] <= sgn_dly[i-1];
      end
    end
  end

  logic               bx, by;
  logic [30:0]        mx1, my1;
  logic signed [31:0] r0, r1;
  logic               f1;

  assign bx  = ovf_x || (qx_raw > VMAX);
  assign by  = ovf_y || (qy_raw > VMAX);
  assign mx1 = bx ? VMAX[30:0] : qx_raw[30:0];
  assign my1 = by ? VMAX[30:0] : qy_raw[30:0];

  logic signed [49:0] mnx, mny;
  logic signed [63:0] mn0, mn1;
  logic               f2;
  logic signed [51:0] den;
  logic signed [63:0] n0, n1;
  logic               f3;

  always_ff @(posedge clk) begin
    if (ce) begin
      r0  <= sgn_dly[DIV_LAT-1][0] ? -{1'b0, mx1} : {1'b0, mx1};
      r1  <= sgn_dly[DIV_LAT-1][1] ? -{1'b0, my1} : {1'b0, my1};
      f1  <= bx | by;
      mnx <= geom.nx * r0;
      mny <= geom.ny * r1;
      mn0 <= 64'(geom.num * r0);
      mn1 <= 64'(geom.num * r1);
      f2  <= f1;
      den <= 52'(mnx) + 52'(mny) + (52'(geom.sp) <<< 16);
      n0  <= mn0;
      n1  <= mn1;
      f3  <= f2;
    end
  end

  // hit point: num * ray / den
  logic signed [63:0] n2;
  logic [63:0]        nm0, nm1, nm2;
  logic [51:0]        dm;
  side_t              side_in;
  side_t              side_dly [DIV_LAT];
  logic [DIV_QW-1:0]  q0, q1, q2;
  logic               o0, o1, o2;

  assign n2  = 64'(geom.num) <<< 16;
  assign nm0 = n0[63] ? -n0 : n0;
  assign nm1 = n1[63] ? -n1 : n1;
  assign nm2 = n2[63] ? -n2 : n2;
  assign dm  = den[51] ? -den : den;

  always_comb begin
    side_in.den0 = (den == '0);
    side_in.neg  = {n2[63] ^ den[51], n1[63] ^ den[51], n0[63] ^ den[51]};
    side_in.nz   = {n2 != '0, n1 != '0, n0 != '0};
    side_in.pos  = {!n2[63], !n1[63], !n0[63]} & side_in.nz;
    // also flags a hit behind the camera (num, den of opposite sign)
    side_in.flag = f3 | side_in.den0 |
                   ((geom.num != '0) && !side_in.den0 && (geom.num[33] != den[51]));
  end

  gpsp_div u_div_0 (.clk (clk), .ce (ce), .num (nm0), .den (dm), .quo (q0), .ovf (o0));
  gpsp_div u_div_1 (.clk (clk), .ce (ce), .num (nm1), .den (dm), .quo (q1), .ovf (o1));
  gpsp_div u_div_2 (.clk (clk), .ce (ce), .num (nm2), .den (dm), .quo (q2), .ovf (o2));

  always_ff @(posedge clk) begin
    if (ce) begin
      side_dly[0] <= side_in;
      for (int i = 1; i < DIV_LAT; i++) begin
        side_dly[i] <= side_dly[i-1];
      end
    end
  end

  side_t       sd;
  logic [42:0] h0, h1, h2;

  assign sd = side_dly[DIV_LAT-1];
  assign h0 = hit_sat(q0, o0, sd.neg[0], sd.den0, sd.pos[0], sd.nz[0]);
  assign h1 = hit_sat(q1, o1, sd.neg[1], sd.den0, sd.pos[1], sd.nz[1]);
  assign h2 = hit_sat(q2, o2, sd.neg[2], sd.den0, sd.pos[2], sd.nz[2]);

  // rotate and map to the top view
  logic signed [41:0]     p0, p1, p2;
  logic                   f4;
  logic signed [57:0]     pa, pb, pc, pd, pe;
  logic                   f5;
  logic signed [58:0]     sx6, sy6;
  logic signed [57:0]     e6;
  logic                   f6;
  logic signed [QW-1:0]   qx7, qy7;
  logic signed [57:0]     e7;
  logic                   f7;
  logic signed [60:0]     g8;
  logic signed [HXW-1:0]  hx8;
  logic signed [57:0]     e8;
  logic                   f8;
  logic signed [WSW-1:0]  ws9;
  logic signed [OXW-1:0]  ox9, ox10, ox11;
  logic                   f9, f10, f11;
  logic signed [WYW-1:0]  wy10;
  logic signed [HYW-1:0]  hy11;
  logic signed [63:0]     rx7, ry7, rhx, rws, rhy;

  assign rx7 = rshr(64'(sx6), 14);
  assign ry7 = rshr(64'(sy6), 14);
  assign rhx = rshr(64'(hx8), 10);
  assign rws = rshr(64'(ws9), 14);
  assign rhy = rshr(64'(hy11), 10);

  always_ff @(posedge clk) begin
    if (ce) begin
      p0   <= h0[41:0];
      p1   <= h1[41:0];
      p2   <= h2[41:0];
      f4   <= sd.flag | h0[42] | h1[42] | h2[42];
      pa   <= geom.cr * p0;
      pb   <= geom.sr * p1;
      pc   <= geom.sr * p0;
      pd   <= geom.cr * p1;
      pe   <= geom.cp * p2;
      f5   <= f4;
      sx6  <= 59'(pa) - 59'(pb);
      sy6  <= 59'(pc) + 59'(pd);
      e6   <= pe;
      f6   <= f5;
      qx7  <= rx7[QW-1:0];
      qy7  <= ry7[QW-1:0];
      e7   <= e6;
      f7   <= f6;
      g8   <= geom.sp * qy7;
      hx8  <= SCALE_S * qx7;
      e8   <= e7;
      f8   <= f7;
      ws9  <= WSW'(g8) + WSW'(e8);
      ox9  <= rhx[OXW-1:0] + OXW'(OX_OFS);
      f9   <= f8;
      wy10 <= rws[WYW-1:0];
      ox10 <= ox9;
      f10  <= f9;
      hy11 <= SCALE_S * wy10;
      ox11 <= ox10;
      f11  <= f10;
      oy   <= OYW'(OY_OFS) - rhy[OYW-1:0];
      ox   <= ox11;
      flag <= f11;
    end
  end

endmodule

[design/ground_plane_segment_projector.sv]
// Ground-plane segment projector.
// Slave stream: one beat carries an image segment (two endpoints, Q12.4 pixels).
// Master stream: one beat per segment with both endpoints mapped to top-view
// pixels (signed Q13.4, saturated) and tuser set when a ray misses the ground
// ahead of the camera or a value saturated.
// The two endpoints run through two identical lanes side by side; each lane
// holds five pipelined dividers (one quotient bit per stage) plus the product
// and rotation stages. One segment is taken every cycle unless a stall
// freezes the pipeline.
// A stalled master side freezes the pipeline only once a finished result
// reaches the last lane stage while the output register is still full; until
// then new beats are taken. No beat is dropped.
// Reset clears all valid state and loads the register defaults (640x480 camera,
// focal 600 px, height 1 m, level). Write registers over APB only while no
// segment is in flight; the derived terms are registered from them.
module ground_plane_segment_projector (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [63:0] s_tdata,   // start_x, start_y, end_x, end_y
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [71:0] m_tdata,   // map_start_x, map_start_y, map_end_x, map_end_y
  output logic        m_tuser,   // out_of_range
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import gpsp_pkg::*;

  cfg_t     cfg;
  geom_t    geom;
  reg_idx_t idx;

  assign idx    = reg_idx_t'(paddr[4:2]);
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.focal_x  <= 24'd153600;
      cfg.focal_y  <= 24'd153600;
      cfg.center_x <= 16'd5120;
      cfg.center_y <= 16'd3840;
      cfg.height   <= 15'd16384;
      cfg.roll     <= 32'd16384;
      cfg.pitch    <= 32'd16384;
    end else if (psel && penable && pwrite) begin
      unique case (idx)
        REG_FOCAL_X:  cfg.focal_x  <= pwdata[23:0];
        REG_FOCAL_Y:  cfg.focal_y  <= pwdata[23:0];
        REG_CENTER_X: cfg.center_x <= pwdata[15:0];
        REG_CENTER_Y: cfg.center_y <= pwdata[15:0];
        REG_HEIGHT:   cfg.height   <= pwdata[14:0];
        REG_ROLL:     cfg.roll     <= pwdata;
        REG_PITCH:    cfg.pitch    <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_FOCAL_X:  prdata = {8'd0, cfg.focal_x};
      REG_FOCAL_Y:  prdata = {8'd0, cfg.focal_y};
      REG_CENTER_X: prdata = {16'd0, cfg.center_x};
      REG_CENTER_Y: prdata = {16'd0, cfg.center_y};
      REG_HEIGHT:   prdata = {17'd0, cfg.height};
      REG_ROLL:     prdata = cfg.roll;
      REG_PITCH:    prdata = cfg.pitch;
      default:      prdata = '0;
    endcase
  end

  // plane normal and numerator, derived from the registers
  logic signed [31:0] nx_prod, ny_prod;
  logic signed [63:0] nx_rnd, ny_rnd;

  assign nx_rnd = rshr(64'(nx_prod), 14);
  assign ny_rnd = rshr(64'(ny_prod), 14);

  always_ff @(posedge clk) begin
    nx_prod  <= $signed(cfg.roll[31:16]) * $signed(cfg.pitch[15:0]);
    ny_prod  <= $signed(cfg.roll[15:0]) * $signed(cfg.pitch[15:0]);
    geom.sr  <= cfg.roll[31:16];
    geom.cr  <= cfg.roll[15:0];
    geom.sp  <= cfg.pitch[31:16];
    geom.cp  <= cfg.pitch[15:0];
    geom.nx  <= nx_rnd[17:0];
    geom.ny  <= ny_rnd[17:0];
    geom.num <= $signed({1'b0, cfg.height}) * geom.ny;
  end

  // pipeline control
  logic [LANE_LAT-1:0] vld;
  logic                ce;
  logic                last;

  assign last     = vld[LANE_LAT-1];
  assign ce       = !(m_tvalid && !m_tready && last);
  assign s_tready = ce;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (ce) begin
      vld <= {vld[LANE_LAT-2:0], s_tvalid};
    end
  end

  logic signed [OXW-1:0] ox_a, ox_b;
  logic signed [OYW-1:0] oy_a, oy_b;
  logic                  fl_a, fl_b;

  gpsp_lane u_lane_start (
    .clk (clk), .ce (ce),
    .pos_x (s_tdata[15:0]), .pos_y (s_tdata[31:16]),
    .cfg (cfg), .geom (geom),
    .ox (ox_a), .oy (oy_a), .flag (fl_a)
  );

  gpsp_lane u_lane_end (
    .clk (clk), .ce (ce),
    .pos_x (s_tdata[47:32]), .pos_y (s_tdata[63:48]),
    .cfg (cfg), .geom (geom),
    .ox (ox_b), .oy (oy_b), .flag (fl_b)
  );

  // merge: clamp both endpoints and combine the flags
  logic [OUT_W:0] sx_a, sy_a, sx_b, sy_b;

  assign sx_a = sat_out(64'(ox_a));
  assign sy_a = sat_out(64'(oy_a));
  assign sx_b = sat_out(64'(ox_b));
  assign sy_b = sat_out(64'(oy_b));

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (ce && last) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ce && last) begin
      m_tdata <= {sy_b[OUT_W-1:0], sx_b[OUT_W-1:0], sy_a[OUT_W-1:0], sx_a[OUT_W-1:0]};
      m_tuser <= fl_a | fl_b | sx_a[OUT_W] | sy_a[OUT_W] | sx_b[OUT_W] | sy_b[OUT_W];
    end
  end

  a_stall_only_on_full: assert property (@(posedge clk) disable iff (rst)
    !s_tready |-> (m_tvalid && !m_tready && last))
    else $error("pipeline stalled without a blocked result");

  a_frozen_on_stall: assert property (@(posedge clk) disable iff (rst)
    !s_tready |=> $stable(vld))
    else $error("valid pipeline moved during stall");

  a_result_loads: assert property (@(posedge clk) disable iff (rst)
    (s_tready && last) |=> m_tvalid)
    else $error("finished segment not moved to the output");

  a_result_drains: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tready && !last) |=> !m_tvalid)
    else $error("output beat repeated");

endmodule
